### hdl/gcu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcu_pkg
// Shared constants, types and the square-root step for the GrowCut cell update.
// ----------------------------------------------------------------------------
package gcu_pkg;

  localparam int LABEL_BITS = 8;
  localparam logic [7:0] LABEL_MASK = 8'((1 << LABEL_BITS) - 1);

  localparam int NLANES = 4;
  // lane pipeline: squared distance, seven root stages, reciprocal product, attack
  localparam int SQ_STAGES = 7;
  localparam int NSTG = SQ_STAGES + 3;

  localparam int D2_W = 18;
  localparam int SQ_W = 27;
  localparam int ROOT_W = 13;
  localparam int PROD_W = 40;

  localparam logic [15:0] ONE_Q15 = 16'd32768;
  // ceil(2^34 / 221): root * 32768 / 7072 == root * 1024 / 221, exact after >> 24
  localparam logic [26:0] RECIP = 27'd77736965;
  localparam int RECIP_SHIFT = 24;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sq_t;

  // one step of the digit-by-digit integer square root
  function automatic sq_t sq_step(input sq_t a, input int e);
    sq_t o;
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    b = SQ_W'(1) << e;
    t = a.r + b;
    if (a.v >= t) begin
      o.v = a.v - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.v = a.v;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### hdl/gcu_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcu_lane
// Attack force of one neighbor: color distance, root, similarity, scaling.
// ----------------------------------------------------------------------------
module gcu_lane (
  input  wire logic                     clk,
  input  wire logic [gcu_pkg::NSTG-1:0] ld,
  input  wire logic [23:0]              center_color,
  input  wire logic [7:0]               center_label,
  input  wire logic [47:0]              nbr,
  input  wire logic                     cell_ok,
  output logic      [15:0]              attack,
  output logic                          act,
  output logic      [7:0]               lab
);
  import gcu_pkg::*;

  logic [7:0]  ad [3];
  logic [15:0] sqr [3];
  logic [D2_W-1:0] d2;
  sq_t sq [SQ_STAGES];
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_c;
  logic [15:0] q;
  logic [15:0] g;
  logic [31:0] gm;

  logic [7:0]  lab_p [NSTG];
  logic [15:0] str_p [NSTG];
  logic        act_p [NSTG];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (center_color[8*c +: 8] >= nbr[8*c +: 8]) begin
        ad[c] = center_color[8*c +: 8] - nbr[8*c +: 8];
      end else begin
        ad[c] = nbr[8*c +: 8] - center_color[8*c +: 8];
      end
      sqr[c] = ad[c] * ad[c];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d2 <= D2_W'(sqr[0]) + D2_W'(sqr[1]) + D2_W'(sqr[2]);
      lab_p[0] <= nbr[31:24];
      str_p[0] <= nbr[47:32];
      act_p[0] <= cell_ok && ((nbr[31:24] & LABEL_MASK) != (center_label & LABEL_MASK));
    end
  end

  for (genvar i = 1; i < NSTG; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (ld[i]) begin
        lab_p[i] <= lab_p[i-1];
        str_p[i] <= str_p[i-1];
        act_p[i] <= act_p[i-1];
      end
    end
  end

  // two root bits per stage, the last stage takes one
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
    sq_t si;
    sq_t s1;
    sq_t s2;
    if (j == 0) begin : g_first
      assign si.v = SQ_W'({d2, 8'd0});
      assign si.r = '0;
    end else begin : g_next
      assign si = sq[j-1];
    end
    assign s1 = sq_step(si, 24 - 4*j);
    if (j < SQ_STAGES - 1) begin : g_two
      assign s2 = sq_step(s1, 22 - 4*j);
    end else begin : g_one
      assign s2 = s1;
    end
    always_ff @(posedge clk) begin
      if (ld[j+1]) begin
        sq[j] <= s2;
      end
    end
  end

  assign prod_c = sq[SQ_STAGES-1].r[ROOT_W-1:0] * RECIP;

  always_ff @(posedge clk) begin
    if (ld[SQ_STAGES+1]) begin
      prod <= prod_c;
    end
  end

  assign q  = prod[RECIP_SHIFT +: 16];
  assign g  = (q > ONE_Q15) ? 16'd0 : ONE_Q15 - q;
  assign gm = g * str_p[SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (ld[SQ_STAGES+2]) begin
      attack <= gm[30:15];
    end
  end

  assign act = act_p[NSTG-1];
  assign lab = lab_p[NSTG-1];

endmodule
`default_nettype wire

### hdl/gcu_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcu_merge
// Picks the strongest attack above the current strength, earliest lane on ties.
// ----------------------------------------------------------------------------
module gcu_merge (
  input  wire logic        clk,
  input  wire logic        ld,
  input  wire logic [7:0]  center_label,
  input  wire logic [15:0] center_strength,
  input  wire logic [15:0] attack [gcu_pkg::NLANES],
  input  wire logic        act [gcu_pkg::NLANES],
  input  wire logic [7:0]  lab [gcu_pkg::NLANES],
  output logic      [7:0]  new_label,
  output logic      [15:0] new_strength,
  output logic             changed
);
  import gcu_pkg::*;

  logic [7:0]  best_lab;
  logic [15:0] best_str;
  logic        won;

  always_comb begin
    best_lab = center_label;
    best_str = center_strength;
    won = 1'b0;
    for (int k = 0; k < NLANES; k++) begin
      if (act[k] && (attack[k] > best_str)) begin
        best_lab = lab[k];
        best_str = attack[k];
        won = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      new_label    <= best_lab;
      new_strength <= best_str;
      changed      <= won;
    end
  end

endmodule
`default_nettype wire

### hdl/growcut_cell_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// growcut_cell_update
// One GrowCut automaton update of a pixel from its four neighbors.
// ----------------------------------------------------------------------------
// Input channel: pixel color, label, strength, four packed neighbor cells and
// their validity mask, transferred when in_valid is high and in_stall is low.
// Output channel: new label, new strength and the changed flag, transferred
// when out_valid is high and out_stall is low.
// Four lanes, one per neighbor, each run a 10-stage pipeline: squared color
// distance, seven square-root stages of two bits each (the last takes one),
// the reciprocal product for the similarity, and the attack multiply. A
// merge stage then picks the winner into the output register. One pixel can
// be taken every cycle while in_stall is low. Empty stages close up, so a
// stalled receiver only stops the input once every stage holds an item.
// Reset (synchronous, rst) empties the pipeline and the output register.
// ----------------------------------------------------------------------------
module growcut_cell_update (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [23:0] center_color,
  input  wire logic [7:0]  center_label,
  input  wire logic [15:0] center_strength,
  input  wire logic [47:0] north_cell,
  input  wire logic [47:0] west_cell,
  input  wire logic [47:0] east_cell,
  input  wire logic [47:0] south_cell,
  input  wire logic [3:0]  neighbor_valid,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic      [7:0]  new_label,
  output logic      [15:0] new_strength,
  output logic             changed,
  output logic             out_valid,
  input  wire logic        out_stall
);
  import gcu_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  logic [47:0]     cells [NLANES];
  logic [15:0]     attack [NLANES];
  logic            act [NLANES];
  logic [7:0]      lab [NLANES];
  logic [7:0]      clab_p [NSTG];
  logic [15:0]     cstr_p [NSTG];

  assign cells[0] = north_cell;
  assign cells[1] = west_cell;
  assign cells[2] = east_cell;
  assign cells[3] = south_cell;

  // a stage loads when it is empty or its item moves on
  always_comb begin
    rdy[NSTG] = !out_valid || !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (rdy[NSTG]) begin
        out_valid <= vld[NSTG-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      clab_p[0] <= center_label;
      cstr_p[0] <= center_strength;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        clab_p[i] <= clab_p[i-1];
        cstr_p[i] <= cstr_p[i-1];
      end
    end
  end

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    gcu_lane u_lane (
      .clk          (clk),
      .ld           (rdy[NSTG-1:0]),
      .center_color (center_color),
      .center_label (center_label),
      .nbr          (cells[k]),
      .cell_ok      (neighbor_valid[k]),
      .attack       (attack[k]),
      .act          (act[k]),
      .lab          (lab[k])
    );
  end

  gcu_merge u_merge (
    .clk             (clk),
    .ld              (rdy[NSTG]),
    .center_label    (clab_p[NSTG-1]),
    .center_strength (cstr_p[NSTG-1]),
    .attack          (attack),
    .act             (act),
    .lab             (lab),
    .new_label       (new_label),
    .new_strength    (new_strength),
    .changed         (changed)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> (vld == '0) && !out_valid)
    else $error("pipeline not empty after reset");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");
  a_win_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && changed) |-> (new_strength != 16'd0))
    else $error("conquest with zero strength");
`endif

endmodule
`default_nettype wire
